// ----- hw/rtl/i2cseq_pkg.sv -----
// Shared types, codes and sequence tables for the I2C EEPROM transfer sequencer.
package i2cseq_pkg;

  localparam int DEF_PAGE_SIZE       = 64;
  localparam int DEF_ACK_QUEUE_DEPTH = 8;
  localparam int JOBQ_DEPTH          = 4;
  localparam int OUTQ_DEPTH          = 8;
  localparam logic [6:0] DEF_DEV_ADDR = 7'd80;

  typedef enum logic [2:0] {
    ACT_BEGIN_READ   = 3'd0,
    ACT_BEGIN_WRITE  = 3'd1,
    ACT_READ_BYTE    = 3'd2,
    ACT_WRITE_BYTE   = 3'd3,
    ACT_FINISH_READ  = 3'd4,
    ACT_FINISH_WRITE = 3'd5,
    ACT_BUS_ACK      = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_WRITE   = 3'd4,
    CMD_READ    = 3'd5,
    CMD_NACK    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_NOPEND  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_COUNTED = 2'd0,
    K_IGNORED = 2'd1,
    K_POLL    = 2'd2
  } ack_kind_t;

  // Command sequences the back end can expand
  typedef enum logic [3:0] {
    SEQ_NONE       = 4'd0,
    SEQ_BEGIN_RD   = 4'd1,
    SEQ_BEGIN_WR   = 4'd2,
    SEQ_RD_BYTE    = 4'd3,
    SEQ_WR_BYTE    = 4'd4,
    SEQ_WR_PAGE    = 4'd5,
    SEQ_FINISH_RD  = 4'd6,
    SEQ_FINISH_WR  = 4'd7,
    SEQ_POLL_NACK  = 4'd8,
    SEQ_POLL_PAGE  = 4'd9,
    SEQ_POLL_FINAL = 4'd10
  } seq_t;

  typedef struct packed {
    seq_t        seq;
    logic [6:0]  dev;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        err;
    status_t     status;
    logic        busy;
  } job_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } cmd_byte_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       err;
    status_t    status;
    logic       busy;
    logic       last;
  } result_t;

  function automatic logic [2:0] seq_len(seq_t s);
    logic [2:0] n;
    unique case (s)
      SEQ_BEGIN_RD:  n = 3'd6;
      SEQ_BEGIN_WR:  n = 3'd4;
      SEQ_WR_PAGE:   n = 3'd4;
      SEQ_FINISH_RD: n = 3'd2;
      SEQ_FINISH_WR: n = 3'd3;
      SEQ_POLL_NACK: n = 3'd2;
      SEQ_POLL_PAGE: n = 3'd5;
      default:       n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic cmd_byte_t mk(cmd_t c, logic [7:0] d);
    cmd_byte_t r;
    r.cmd  = c;
    r.data = d;
    return r;
  endfunction

  function automatic cmd_byte_t seq_step(job_t j, logic [2:0] step);
    cmd_byte_t  r;
    logic [7:0] hw;
    logic [7:0] hr;
    hw = {j.dev, 1'b0};
    hr = {j.dev, 1'b1};
    r  = mk(CMD_NONE, 8'd0);
    unique case (j.seq)
      SEQ_BEGIN_RD, SEQ_BEGIN_WR: begin
        case (step)
          3'd0:    r = mk(CMD_START, 8'd0);
          3'd1:    r = mk(CMD_WRITE, hw);
          3'd2:    r = mk(CMD_WRITE, j.addr[15:8]);
          3'd3:    r = mk(CMD_WRITE, j.addr[7:0]);
          3'd4:    r = mk(CMD_RESTART, 8'd0);
          3'd5:    r = mk(CMD_WRITE, hr);
          default: r = mk(CMD_NONE, 8'd0);
        endcase
      end
      SEQ_RD_BYTE: r = mk(CMD_READ, 8'd0);
      SEQ_WR_BYTE: r = mk(CMD_WRITE, j.data);
      SEQ_WR_PAGE: begin
        case (step)
          3'd0:    r = mk(CMD_WRITE, j.data);
          3'd1:    r = mk(CMD_STOP, 8'd0);
          3'd2:    r = mk(CMD_START, 8'd0);
          default: r = mk(CMD_WRITE, hw);
        endcase
      end
      SEQ_FINISH_RD: r = (step == 3'd0) ? mk(CMD_NACK, 8'd0) : mk(CMD_STOP, 8'd0);
      SEQ_FINISH_WR: begin
        case (step)
          3'd0:    r = mk(CMD_STOP, 8'd0);
          3'd1:    r = mk(CMD_START, 8'd0);
          default: r = mk(CMD_WRITE, hw);
        endcase
      end
      SEQ_POLL_NACK: r = (step == 3'd0) ? mk(CMD_RESTART, 8'd0) : mk(CMD_WRITE, hw);
      SEQ_POLL_PAGE: begin
        case (step)
          3'd0:    r = mk(CMD_STOP, 8'd0);
          3'd1:    r = mk(CMD_START, 8'd0);
          3'd2:    r = mk(CMD_WRITE, hw);
          3'd3:    r = mk(CMD_WRITE, j.addr[15:8]);
          default: r = mk(CMD_WRITE, j.addr[7:0]);
        endcase
      end
      SEQ_POLL_FINAL: r = mk(CMD_STOP, 8'd0);
      default:        r = mk(CMD_NONE, 8'd0);
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/i2cseq_front.sv -----
// Front end: classifies requests, tracks mode and pending acknowledges, emits jobs.
module i2cseq_front import i2cseq_pkg::*; #(
  parameter int PAGE_SIZE       = DEF_PAGE_SIZE,
  parameter int ACK_QUEUE_DEPTH = DEF_ACK_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [2:0]  action,
  input  logic [15:0] address,
  input  logic [7:0]  data_byte,
  input  logic        nack,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_dev,
  output job_t        job
);

  localparam int CW = $clog2(ACK_QUEUE_DEPTH + 1);
  localparam int PW = $clog2(PAGE_SIZE);

  typedef enum logic [4:0] {
    M_IDLE      = 5'b00001,
    M_READ      = 5'b00010,
    M_WRITE     = 5'b00100,
    M_PAGEPOLL  = 5'b01000,
    M_FINALPOLL = 5'b10000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic        err_r, err_nxt;
  logic [6:0]  dev_r;
  ack_kind_t   kq_r   [ACK_QUEUE_DEPTH];
  ack_kind_t   kq_nxt [ACK_QUEUE_DEPTH];
  ack_kind_t   kq_pop [ACK_QUEUE_DEPTH];
  logic [CW-1:0] kcnt_r, kcnt_nxt, kcnt_pop;

  seq_t        seq;
  status_t     status;
  logic        do_pop;
  logic [2:0]  npush;
  ack_kind_t   kinds [4];
  logic [15:0] next_addr;
  logic        page_end;
  logic [CW:0] cnt_wide;
  logic [CW:0] push_end;
  logic [CW-1:0] off;
  logic        room1, room2, room3, room4;

  assign next_addr = cur_r + 16'd1;
  assign page_end  = (next_addr[PW-1:0] == '0);
  assign cnt_wide  = {1'b0, kcnt_r};
  assign room1 = (cnt_wide + (CW+1)'(1)) <= (CW+1)'(ACK_QUEUE_DEPTH);
  assign room2 = (cnt_wide + (CW+1)'(2)) <= (CW+1)'(ACK_QUEUE_DEPTH);
  assign room3 = (cnt_wide + (CW+1)'(3)) <= (CW+1)'(ACK_QUEUE_DEPTH);
  assign room4 = (cnt_wide + (CW+1)'(4)) <= (CW+1)'(ACK_QUEUE_DEPTH);

  always_comb begin
    mode_nxt = mode_r;
    cur_nxt  = cur_r;
    err_nxt  = err_r;
    seq      = SEQ_NONE;
    status   = ST_OK;
    do_pop   = 1'b0;
    npush    = 3'd0;
    for (int i = 0; i < 4; i++) kinds[i] = K_COUNTED;
    unique case (action_t'(action))
      ACT_BEGIN_READ: begin
        if (mode_r != M_IDLE || !room4) begin
          status = ST_REJECT;
        end else begin
          err_nxt  = 1'b0;
          cur_nxt  = address;
          seq      = SEQ_BEGIN_RD;
          npush    = 3'd4;
          kinds[3] = K_IGNORED;
          mode_nxt = M_READ;
        end
      end
      ACT_BEGIN_WRITE: begin
        if (mode_r != M_IDLE || !room3) begin
          status = ST_REJECT;
        end else begin
          err_nxt  = 1'b0;
          cur_nxt  = address;
          seq      = SEQ_BEGIN_WR;
          npush    = 3'd3;
          mode_nxt = M_WRITE;
        end
      end
      ACT_READ_BYTE: begin
        if (mode_r != M_READ) status = ST_REJECT;
        else                  seq    = SEQ_RD_BYTE;
      end
      ACT_WRITE_BYTE: begin
        if (mode_r != M_WRITE || !(page_end ? room2 : room1)) begin
          status = ST_REJECT;
        end else begin
          cur_nxt = next_addr;
          if (page_end) begin
            seq      = SEQ_WR_PAGE;
            npush    = 3'd2;
            kinds[1] = K_POLL;
            mode_nxt = M_PAGEPOLL;
          end else begin
            seq   = SEQ_WR_BYTE;
            npush = 3'd1;
          end
        end
      end
      ACT_FINISH_READ: begin
        if (mode_r != M_READ) begin
          status = ST_REJECT;
        end else begin
          seq      = SEQ_FINISH_RD;
          mode_nxt = M_IDLE;
        end
      end
      ACT_FINISH_WRITE: begin
        if (mode_r != M_WRITE || !room1) begin
          status = ST_REJECT;
        end else begin
          seq      = SEQ_FINISH_WR;
          npush    = 3'd1;
          kinds[0] = K_POLL;
          mode_nxt = M_FINALPOLL;
        end
      end
      ACT_BUS_ACK: begin
        if (kcnt_r == '0) begin
          status = ST_NOPEND;
        end else begin
          do_pop = 1'b1;
          case (kq_r[0])
            K_COUNTED: if (nack) err_nxt = 1'b1;
            K_POLL: begin
              if (mode_r == M_PAGEPOLL || mode_r == M_FINALPOLL) begin
                if (nack) begin
                  seq      = SEQ_POLL_NACK;
                  npush    = 3'd1;
                  kinds[0] = K_POLL;
                end else if (mode_r == M_PAGEPOLL) begin
                  seq      = SEQ_POLL_PAGE;
                  npush    = 3'd3;
                  mode_nxt = M_WRITE;
                end else begin
                  seq      = SEQ_POLL_FINAL;
                  mode_nxt = M_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: status = ST_REJECT;
    endcase
  end

  // Pop the head, then append the new kinds; anything past the depth is dropped
  always_comb begin
    for (int i = 0; i < ACK_QUEUE_DEPTH - 1; i++) begin
      kq_pop[i] = do_pop ? kq_r[i+1] : kq_r[i];
    end
    kq_pop[ACK_QUEUE_DEPTH-1] = kq_r[ACK_QUEUE_DEPTH-1];
    kcnt_pop = do_pop ? kcnt_r - CW'(1) : kcnt_r;
    push_end = {1'b0, kcnt_pop} + (CW+1)'(npush);
    for (int i = 0; i < ACK_QUEUE_DEPTH; i++) begin
      off = CW'(i) - kcnt_pop;
      if (CW'(i) >= kcnt_pop && (CW+1)'(i) < push_end) kq_nxt[i] = kinds[off[1:0]];
      else                                              kq_nxt[i] = kq_pop[i];
    end
    if (push_end > (CW+1)'(ACK_QUEUE_DEPTH)) kcnt_nxt = CW'(ACK_QUEUE_DEPTH);
    else                                     kcnt_nxt = push_end[CW-1:0];
  end

  always_comb begin
    job.seq    = seq;
    job.dev    = dev_r;
    job.addr   = cur_nxt;
    job.data   = data_byte;
    job.err    = err_nxt;
    job.status = status;
    job.busy   = (mode_nxt == M_PAGEPOLL) || (mode_nxt == M_FINALPOLL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      cur_r  <= 16'd0;
      err_r  <= 1'b0;
      kcnt_r <= '0;
      dev_r  <= DEF_DEV_ADDR;
    end else begin
      if (cfg_we) dev_r <= cfg_dev;
      if (acc) begin
        mode_r <= mode_nxt;
        cur_r  <= cur_nxt;
        err_r  <= err_nxt;
        kcnt_r <= kcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < ACK_QUEUE_DEPTH; i++) kq_r[i] <= kq_nxt[i];
    end
  end

  a_kcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kcnt_r <= CW'(ACK_QUEUE_DEPTH))
    else $error("acknowledge queue count past depth");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && status == ST_REJECT |=> $stable(mode_r) && $stable(kcnt_r) && $stable(cur_r))
    else $error("rejected request changed state");

  a_empty_ack_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && status == ST_NOPEND |=> $stable(mode_r) && kcnt_r == '0)
    else $error("acknowledge with nothing pending changed state");

endmodule

// ----- hw/rtl/i2cseq_jobq.sv -----
// Short job queue between the front end and the command expander.
module i2cseq_jobq import i2cseq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  job_t wdata,
  input  logic rd,
  output job_t head,
  output logic full,
  output logic empty
);

  localparam int AW = $clog2(JOBQ_DEPTH);
  localparam int CW = $clog2(JOBQ_DEPTH + 1);

  job_t          q_r [JOBQ_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(JOBQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + AW'(1);
      if (rd) rp_r <= rp_r + AW'(1);
      if (wr && !rd)      cnt_r <= cnt_r + CW'(1);
      else if (rd && !wr) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !rd |-> !wr)
    else $error("job queue written while full");

endmodule

// ----- hw/rtl/i2cseq_back.sv -----
// Back end: expands each job into bus commands and buffers them as result items.
module i2cseq_back import i2cseq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  job_t    job,
  input  logic    job_empty,
  output logic    job_pop,
  input  logic    pop,
  output logic    empty,
  output result_t res
);

  localparam int AW = $clog2(OUTQ_DEPTH);
  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  result_t       oq_r [OUTQ_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic [2:0]    step_r, step_nxt;
  cmd_byte_t     cb;
  logic          last;
  logic          issue;
  logic          take;
  result_t       wres;

  assign cb    = seq_step(job, step_r);
  assign last  = (step_r == seq_len(job.seq) - 3'd1);
  assign issue = !job_empty && (cnt_r != CW'(OUTQ_DEPTH));
  assign take  = pop && !empty;
  assign job_pop  = issue && last;
  assign step_nxt = last ? 3'd0 : step_r + 3'd1;

  always_comb begin
    wres.cmd    = cb.cmd;
    wres.data   = cb.data;
    wres.err    = job.err;
    wres.status = job.status;
    wres.busy   = job.busy;
    wres.last   = last;
  end

  assign empty = (cnt_r == '0);
  assign res   = oq_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
    end else begin
      if (issue) begin
        step_r <= step_nxt;
        wp_r   <= wp_r + AW'(1);
      end
      if (take) rp_r <= rp_r + AW'(1);
      if (issue && !take)      cnt_r <= cnt_r + CW'(1);
      else if (take && !issue) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) oq_r[wp_r] <= wres;
  end

  a_outq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(OUTQ_DEPTH))
    else $error("result queue count past depth");

  a_step_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != 3'd0 |-> !job_empty && step_r < seq_len(job.seq))
    else $error("expansion step without a job in flight");

endmodule

// ----- hw/rtl/i2c_eeprom_transfer_sequencer_top.sv -----
// Top level of the I2C EEPROM transfer sequencer: front end, job queue, command expander.
// Each item is written into the job queue, then its commands into the result queue, ahead of the result ports.
// The four-entry job queue takes one item per cycle while not full; the expander issues
// one command per cycle while the result queue has room, one to six commands per item.
// Synchronous active-low reset empties the job, result and acknowledge queues, sets idle
// mode, address and error to zero, and the device address to 80.
module i2c_eeprom_transfer_sequencer_top import i2cseq_pkg::*; #(
  parameter int PAGE_SIZE       = DEF_PAGE_SIZE,
  parameter int ACK_QUEUE_DEPTH = DEF_ACK_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data_byte,
  input  logic        in_nack,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_command,
  output logic [7:0]  out_bus_byte,
  output logic        out_error,
  output logic [1:0]  out_status,
  output logic        out_busy_res,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_device_address
);

  job_t    job_in;
  job_t    job_head;
  logic    job_empty;
  logic    job_pop;
  logic    acc;
  result_t res;

  assign cfg_ready = 1'b1;
  assign acc       = push && !full;

  i2cseq_front #(
    .PAGE_SIZE       (PAGE_SIZE),
    .ACK_QUEUE_DEPTH (ACK_QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .action    (in_action),
    .address   (in_address),
    .data_byte (in_data_byte),
    .nack      (in_nack),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_dev   (cfg_device_address),
    .job       (job_in)
  );

  i2cseq_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (acc),
    .wdata (job_in),
    .rd    (job_pop),
    .head  (job_head),
    .full  (full),
    .empty (job_empty)
  );

  i2cseq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_head),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign out_command  = res.cmd;
  assign out_bus_byte = res.data;
  assign out_error    = res.err;
  assign out_status   = res.status;
  assign out_busy_res = res.busy;
  assign out_last     = res.last;

endmodule

// ----- dv/i2c_eeprom_transfer_sequencer_top_test.sv -----
// Self-checking testbench for the I2C EEPROM transfer sequencer.
`timescale 1ns / 100ps

module i2c_eeprom_transfer_sequencer_top_test;
  import i2cseq_pkg::*;

  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [4:0] {
    MD_IDLE       = 5'b00001,
    MD_READ       = 5'b00010,
    MD_WRITE      = 5'b00100,
    MD_PAGE_POLL  = 5'b01000,
    MD_FINAL_POLL = 5'b10000
  } seq_mode_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
    logic        nack;
  } host_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  in_action = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_data_byte = '0;
  logic        in_nack = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_command;
  logic [7:0]  out_bus_byte;
  logic        out_error;
  logic [1:0]  out_status;
  logic        out_busy_res;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_device_address = '0;

  // Pending host requests, expected bus commands, and the predicted sequencer state
  host_req_t   host_reqs[$];
  result_t     expected_cmds[$];
  cmd_byte_t   step_cmds[$];
  ack_kind_t   ack_pend[$];
  seq_mode_t   seq_mode = MD_IDLE;
  logic [15:0] cur_addr = '0;
  logic        err_flag = 1'b0;
  logic [6:0]  dev_addr = DEF_DEV_ADDR;

  int          fails = 0;
  int          planned = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_start = 1'b0;
  result_t     want;

  i2c_eeprom_transfer_sequencer_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_action          (in_action),
    .in_address         (in_address),
    .in_data_byte       (in_data_byte),
    .in_nack            (in_nack),
    .empty              (empty),
    .pop                (pop),
    .out_command        (out_command),
    .out_bus_byte       (out_bus_byte),
    .out_error          (out_error),
    .out_status         (out_status),
    .out_busy_res       (out_busy_res),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_device_address (cfg_device_address)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void add_cmd(cmd_t c, logic [7:0] d);
    cmd_byte_t cb;
    cb.cmd  = c;
    cb.data = d;
    step_cmds.push_back(cb);
  endfunction

  function automatic void push_ack(ack_kind_t kind);
    // drop when the acknowledge queue is full
    if (ack_pend.size() < DEF_ACK_QUEUE_DEPTH) ack_pend.push_back(kind);
  endfunction

  function automatic bit has_room(int need);
    return ack_pend.size() + need <= DEF_ACK_QUEUE_DEPTH;
  endfunction

  function automatic void write_counted(logic [7:0] b);
    add_cmd(CMD_WRITE, b);
    push_ack(K_COUNTED);
  endfunction

  function automatic void address_phase();
    add_cmd(CMD_START, 8'd0);
    write_counted({dev_addr, 1'b0});
    write_counted(cur_addr[15:8]);
    write_counted(cur_addr[7:0]);
  endfunction

  function automatic void poll_phase(cmd_t opener);
    add_cmd(opener, 8'd0);
    add_cmd(CMD_WRITE, {dev_addr, 1'b0});
    push_ack(K_POLL);
  endfunction

  function automatic void sequence_request(host_req_t r);
    status_t     st;
    logic [15:0] nxt;
    bit          page_end;
    bit          polling;
    ack_kind_t   kind;
    result_t     res;
    st       = ST_OK;
    nxt      = cur_addr + 16'd1;
    page_end = (nxt % DEF_PAGE_SIZE) == 0;
    polling  = (seq_mode == MD_PAGE_POLL) || (seq_mode == MD_FINAL_POLL);
    step_cmds.delete();
    case (r.action)
      ACT_BEGIN_READ: begin
        if (seq_mode != MD_IDLE || !has_room(4)) begin
          st = ST_REJECT;
        end else begin
          err_flag = 1'b0;
          cur_addr = r.address;
          address_phase();
          add_cmd(CMD_RESTART, 8'd0);
          add_cmd(CMD_WRITE, {dev_addr, 1'b1});
          push_ack(K_IGNORED);
          seq_mode = MD_READ;
        end
      end
      ACT_BEGIN_WRITE: begin
        if (seq_mode != MD_IDLE || !has_room(3)) begin
          st = ST_REJECT;
        end else begin
          err_flag = 1'b0;
          cur_addr = r.address;
          address_phase();
          seq_mode = MD_WRITE;
        end
      end
      ACT_READ_BYTE: begin
        if (seq_mode != MD_READ) st = ST_REJECT;
        else add_cmd(CMD_READ, 8'd0);
      end
      ACT_WRITE_BYTE: begin
        if (seq_mode != MD_WRITE || !has_room(page_end ? 2 : 1)) begin
          st = ST_REJECT;
        end else begin
          write_counted(r.data);
          cur_addr = nxt;
          // close the page and poll until the device is ready again
          if (page_end) begin
            add_cmd(CMD_STOP, 8'd0);
            poll_phase(CMD_START);
            seq_mode = MD_PAGE_POLL;
          end
        end
      end
      ACT_FINISH_READ: begin
        if (seq_mode != MD_READ) begin
          st = ST_REJECT;
        end else begin
          add_cmd(CMD_NACK, 8'd0);
          add_cmd(CMD_STOP, 8'd0);
          seq_mode = MD_IDLE;
        end
      end
      ACT_FINISH_WRITE: begin
        if (seq_mode != MD_WRITE || !has_room(1)) begin
          st = ST_REJECT;
        end else begin
          add_cmd(CMD_STOP, 8'd0);
          poll_phase(CMD_START);
          seq_mode = MD_FINAL_POLL;
        end
      end
      ACT_BUS_ACK: begin
        if (ack_pend.size() == 0) begin
          st = ST_NOPEND;
        end else begin
          kind = ack_pend.pop_front();
          if (kind == K_COUNTED) begin
            if (r.nack) err_flag = 1'b1;
          end else if (kind == K_POLL && polling) begin
            if (r.nack) begin
              poll_phase(CMD_RESTART);
            end else begin
              add_cmd(CMD_STOP, 8'd0);
              if (seq_mode == MD_PAGE_POLL) begin
                address_phase();
                seq_mode = MD_WRITE;
              end else begin
                seq_mode = MD_IDLE;
              end
            end
          end
        end
      end
      default: st = ST_REJECT;
    endcase
    if (step_cmds.size() == 0) add_cmd(CMD_NONE, 8'd0);
    foreach (step_cmds[i]) begin
      res.cmd    = step_cmds[i].cmd;
      res.data   = step_cmds[i].data;
      res.err    = err_flag;
      res.status = st;
      res.busy   = (seq_mode == MD_PAGE_POLL) || (seq_mode == MD_FINAL_POLL);
      res.last   = (i == step_cmds.size() - 1);
      expected_cmds.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------- driver and monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) sequence_request(host_reqs.pop_front());
      // hold the item on the ports while the block is full
      if (!push || !full) begin
        if (host_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push         <= 1'b1;
          in_action    <= host_reqs[0].action;
          in_address   <= host_reqs[0].address;
          in_data_byte <= host_reqs[0].data;
          in_nack      <= host_reqs[0].nack;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_cmds.size() == 0) begin
          $error("command %0d arrived with nothing expected", out_command);
          fails++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("command", 8'(want.cmd), 8'(out_command));
          check_field("bus_byte", want.data, out_bus_byte);
          check_field("error", 8'(want.err), 8'(out_error));
          check_field("status", 8'(want.status), 8'(out_status));
          check_field("busy_res", 8'(want.busy), 8'(out_busy_res));
          check_field("last", 8'(want.last), 8'(out_last));
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void add_req(logic [2:0] act, logic [15:0] a, logic [7:0] d, logic nk);
    host_req_t r;
    r.action  = act;
    r.address = a;
    r.data    = d;
    r.nack    = nk;
    host_reqs.push_back(r);
    planned++;
  endfunction

  function automatic void queue_acks(int n);
    repeat (n) add_req(ACT_BUS_ACK, 16'($urandom), 8'($urandom), $urandom_range(7) == 0);
  endfunction

  function automatic void queue_poll_acks();
    repeat ($urandom_range(2)) add_req(ACT_BUS_ACK, 16'($urandom), 8'($urandom), 1'b1);
    add_req(ACT_BUS_ACK, 16'($urandom), 8'($urandom), 1'b0);
  endfunction

  task automatic write_device_address(logic [6:0] v);
    cfg_device_address <= v;
    cfg_valid          <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dev_addr = v;
  endtask

  task automatic wait_drained();
    while (host_reqs.size() != 0 || push || expected_cmds.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    int          pick;
    int          nbytes;
    int          due;
    int          k;
    int          target;
    logic [15:0] wa;
    logic [6:0]  dev_v;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  dev_v = 7'h7f; end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  dev_v = 7'h00; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; dev_v = 7'($urandom); end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; dev_v = DEF_DEV_ADDR; end
      endcase
      write_device_address(dev_v);
      if (phase == 0) begin
        add_req(ACT_BUS_ACK, 16'h0000, 8'h00, 1'b1);
        add_req(ACT_UNUSED, 16'hffff, 8'hff, 1'b1);
        add_req(ACT_READ_BYTE, 16'h0000, 8'h00, 1'b0);
        add_req(ACT_BEGIN_READ, 16'hffff, 8'h00, 1'b0);
        add_req(ACT_BEGIN_WRITE, 16'h1234, 8'h00, 1'b0);
        add_req(ACT_READ_BYTE, 16'h0000, 8'hff, 1'b1);
        add_req(ACT_BUS_ACK, 16'h0000, 8'h00, 1'b1);
        add_req(ACT_BUS_ACK, 16'h0000, 8'h00, 1'b0);
        add_req(ACT_BUS_ACK, 16'h0000, 8'h00, 1'b0);
        add_req(ACT_BUS_ACK, 16'h0000, 8'h00, 1'b1);
        add_req(ACT_FINISH_READ, 16'h0000, 8'h00, 1'b0);
        // start at the top of memory so the first byte wraps onto a new page
        add_req(ACT_BEGIN_WRITE, 16'hffff, 8'h00, 1'b0);
        add_req(ACT_WRITE_BYTE, 16'h0000, 8'ha5, 1'b0);
        add_req(ACT_WRITE_BYTE, 16'h0000, 8'h00, 1'b0);
        repeat (4) add_req(ACT_BUS_ACK, 16'h0000, 8'h00, 1'b0);
        add_req(ACT_BUS_ACK, 16'h0000, 8'h00, 1'b1);
        add_req(ACT_BUS_ACK, 16'h0000, 8'h00, 1'b0);
        add_req(ACT_WRITE_BYTE, 16'hffff, 8'h5a, 1'b1);
        add_req(ACT_FINISH_WRITE, 16'h0000, 8'h00, 1'b0);
        repeat (4) add_req(ACT_BUS_ACK, 16'h0000, 8'h00, 1'b0);
        add_req(ACT_BUS_ACK, 16'h0000, 8'h00, 1'b0);
      end
      target = planned + 42;
      while (planned < target) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          wa = 16'($urandom);
          if ($urandom_range(1)) wa[5:0] = 6'($urandom_range(63, 56));
          nbytes = $urandom_range(9);
          add_req(ACT_BEGIN_WRITE, wa, 8'($urandom), 1'($urandom));
          due = 3;
          repeat (nbytes) begin
            // keep room for a page-closing byte and its poll
            if (due > DEF_ACK_QUEUE_DEPTH - 2) begin
              queue_acks(due);
              due = 0;
            end else if ($urandom_range(2) == 0) begin
              k = $urandom_range(due);
              queue_acks(k);
              due -= k;
            end
            wa = wa + 16'd1;
            add_req(ACT_WRITE_BYTE, 16'($urandom), 8'($urandom), 1'($urandom));
            due++;
            if (wa % DEF_PAGE_SIZE == 0) begin
              queue_acks(due);
              queue_poll_acks();
              due = 3;
            end
          end
          add_req(ACT_FINISH_WRITE, 16'($urandom), 8'($urandom), 1'($urandom));
          queue_acks(due);
          queue_poll_acks();
        end else if (pick < 75) begin
          add_req(ACT_BEGIN_READ, 16'($urandom), 8'($urandom), 1'($urandom));
          due = 4;
          repeat ($urandom_range(5)) begin
            if ($urandom_range(2) == 0) begin
              k = $urandom_range(due);
              queue_acks(k);
              due -= k;
            end
            add_req(ACT_READ_BYTE, 16'($urandom), 8'($urandom), 1'($urandom));
          end
          add_req(ACT_FINISH_READ, 16'($urandom), 8'($urandom), 1'($urandom));
          queue_acks(due);
        end else if (pick < 92) begin
          add_req(3'($urandom_range(7)), 16'($urandom), 8'($urandom), 1'($urandom));
        end else begin
          // abandoned write: no finish and no acknowledgements
          add_req(ACT_BEGIN_WRITE, 16'($urandom), 8'($urandom), 1'($urandom));
          repeat ($urandom_range(4)) begin
            add_req(ACT_WRITE_BYTE, 16'($urandom), 8'($urandom), 1'($urandom));
          end
        end
      end
      if (phase == 0) begin
        // stall the receiver while the sender keeps offering items
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      wait_drained();
    end
    if (fails == 0) begin
      $display("i2c_eeprom_transfer_sequencer_top_test OK");
    end else begin
      $display("i2c_eeprom_transfer_sequencer_top_test NOT OK");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("i2c_eeprom_transfer_sequencer_top_test NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/i2cseq_pkg.sv
hw/rtl/i2cseq_front.sv
hw/rtl/i2cseq_jobq.sv
hw/rtl/i2cseq_back.sv
hw/rtl/i2c_eeprom_transfer_sequencer_top.sv
dv/i2c_eeprom_transfer_sequencer_top_test.sv
